[src/x86alu_pkg.sv]
// ----------------------------------------------------------------------------
// x86alu_pkg
// shared types, opcodes and helpers for the x86 integer alu
// ----------------------------------------------------------------------------
package x86alu_pkg;

    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 72;

    typedef enum logic [4:0] {
        OP_ADD  = 5'd0,  OP_ADC  = 5'd1,  OP_SUB  = 5'd2,  OP_SBB  = 5'd3,
        OP_AND  = 5'd4,  OP_OR   = 5'd5,  OP_XOR  = 5'd6,  OP_SHL  = 5'd7,
        OP_SAL  = 5'd8,  OP_SHR  = 5'd9,  OP_SAR  = 5'd10, OP_MUL  = 5'd11,
        OP_IMUL = 5'd12, OP_DIV  = 5'd13, OP_IDIV = 5'd14, OP_MOD  = 5'd15,
        OP_IMOD = 5'd16
    } t_op;

    localparam logic [1:0] SZ_8  = 2'd0;
    localparam logic [1:0] SZ_16 = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_DIV, ST_FIX, ST_OUT
    } t_state;

    typedef struct packed {
        logic cf;
        logic pf;
        logic zf;
        logic sf;
        logic of;
    } t_flags;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture the input beat
        logic fast;      // finish an alu op, unused code or zero-divisor divide
        logic mul_fin;   // finish multiply
        logic div_init;  // start division
        logic div_step;  // one quotient bit
        logic div_fin;   // finish division
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_mul;
        logic is_div;
        logic div_zero;
        logic div_last;
    } t_stat;

    function automatic logic [5:0] width_of(input logic [1:0] sel);
        logic [5:0] w;
        case (sel)
            SZ_8:    w = 6'd8;
            SZ_16:   w = 6'd16;
            default: w = 6'd32;
        endcase
        return w;
    endfunction

    function automatic logic [31:0] mask_of(input logic [1:0] sel);
        logic [31:0] m;
        case (sel)
            SZ_8:    m = 32'h0000_00FF;
            SZ_16:   m = 32'h0000_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    // sign extend a sized value to 32 bits
    function automatic logic [31:0] sx32(input logic [31:0] v, input logic [1:0] sel);
        logic [31:0] r;
        case (sel)
            SZ_8:    r = {{24{v[7]}}, v[7:0]};
            SZ_16:   r = {{16{v[15]}}, v[15:0]};
            default: r = v;
        endcase
        return r;
    endfunction

endpackage

[src/x86alu_ctrl.sv]
// ----------------------------------------------------------------------------
// x86alu_ctrl
// sequencer: fast alu ops, registered multiply, iterative divide
// ----------------------------------------------------------------------------
module x86alu_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output x86alu_pkg::t_cmd   o_cmd,
    input  x86alu_pkg::t_stat  i_stat
);

    x86alu_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= x86alu_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            x86alu_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = x86alu_pkg::ST_FIX;
                end
            end
            x86alu_pkg::ST_FIX: begin
                if (i_stat.is_mul) begin
                    n_state = x86alu_pkg::ST_MUL;
                end else if (i_stat.is_div && !i_stat.div_zero) begin
                    n_state = x86alu_pkg::ST_DIV;
                end else begin
                    n_state = x86alu_pkg::ST_OUT;
                end
            end
            x86alu_pkg::ST_MUL: n_state = x86alu_pkg::ST_OUT;
            x86alu_pkg::ST_DIV: begin
                if (i_stat.div_last) begin
                    n_state = x86alu_pkg::ST_OUT;
                end
            end
            x86alu_pkg::ST_OUT: begin
                if (i_out_ready) begin
                    n_state = x86alu_pkg::ST_IDLE;
                end
            end
            default: n_state = x86alu_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            x86alu_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            x86alu_pkg::ST_FIX: begin
                if (i_stat.is_mul) begin
                    o_cmd = '0;
                end else if (i_stat.is_div && !i_stat.div_zero) begin
                    o_cmd.div_init = 1'b1;
                end else begin
                    o_cmd.fast = 1'b1;
                end
            end
            x86alu_pkg::ST_MUL: o_cmd.mul_fin = 1'b1;
            x86alu_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                o_cmd.div_fin  = i_stat.div_last;
            end
            x86alu_pkg::ST_OUT: o_out_valid = 1'b1;
            default: o_cmd = '0;
        endcase
    end

endmodule

[src/x86alu_dp.sv]
// ----------------------------------------------------------------------------
// x86alu_dp
// operand registers, combinational alu, multiplier and restoring divider
// ----------------------------------------------------------------------------
module x86alu_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  x86alu_pkg::t_cmd   i_cmd,
    output x86alu_pkg::t_stat  o_stat,
    input  logic [4:0]         i_req_type,
    input  logic [31:0]        i_src,
    input  logic [63:0]        i_dest,
    input  logic [1:0]         i_size,
    output logic [63:0]        o_result,
    output x86alu_pkg::t_flags o_flags,
    output logic               o_derr
);

    logic [4:0]  r_op;
    logic [31:0] r_src;
    logic [63:0] r_dest;
    logic [1:0]  r_size;
    x86alu_pkg::t_flags r_flags, n_flags;
    logic [63:0] r_res, n_res;
    logic        r_derr;
    logic [63:0] r_prod;

    // divider: unsigned magnitudes, 64-bit dividend shifted left one bit per step
    logic [63:0] r_quo;
    logic [32:0] r_rem;
    logic [31:0] r_dvs;
    logic [6:0]  r_cnt;
    logic        r_nq, r_nr;

    logic [5:0]  w;
    logic [31:0] m, s, d, msb;
    logic        signed_div, is_mul_op, is_div_op;
    logic [31:0] sdv;
    logic [63:0] dvd_u, dvd_s;

    assign w   = x86alu_pkg::width_of(r_size);
    assign m   = x86alu_pkg::mask_of(r_size);
    assign s   = r_src & m;
    assign d   = r_dest[31:0] & m;
    assign msb = m ^ (m >> 1);

    assign is_mul_op  = (r_op == x86alu_pkg::OP_MUL) || (r_op == x86alu_pkg::OP_IMUL);
    assign signed_div = (r_op == x86alu_pkg::OP_IDIV) || (r_op == x86alu_pkg::OP_IMOD);
    assign is_div_op  = signed_div || (r_op == x86alu_pkg::OP_DIV)
                      || (r_op == x86alu_pkg::OP_MOD);

    // dividend at twice the width
    always_comb begin
        case (r_size)
            x86alu_pkg::SZ_8: begin
                dvd_u = {48'd0, r_dest[15:0]};
                dvd_s = {{48{r_dest[15]}}, r_dest[15:0]};
            end
            x86alu_pkg::SZ_16: begin
                dvd_u = {32'd0, r_dest[31:0]};
                dvd_s = {{32{r_dest[31]}}, r_dest[31:0]};
            end
            default: begin
                dvd_u = r_dest;
                dvd_s = r_dest;
            end
        endcase
    end

    assign sdv = signed_div ? x86alu_pkg::sx32(s, r_size) : s;

    assign o_stat.is_mul   = is_mul_op;
    assign o_stat.is_div   = is_div_op;
    assign o_stat.div_zero = (s == 32'd0);
    assign o_stat.div_last = (r_cnt == 7'd63);

    // combinational operations: add/sub, logic and shifts
    logic [32:0] sum;
    logic        cin, par;
    logic [31:0] k;
    logic [31:0] sxd;
    logic signed [31:0] sar_v;
    logic [31:0] sh_res;
    logic        sh_cf;
    logic [4:0]  kk;

    always_comb begin
        n_flags = r_flags;
        n_res   = 64'd0;
        cin     = r_flags.cf && ((r_op == x86alu_pkg::OP_ADC) || (r_op == x86alu_pkg::OP_SBB));
        sum     = 33'd0;
        k       = r_src;
        sxd     = x86alu_pkg::sx32(d, r_size);
        sar_v   = $signed(sxd) >>> k[4:0];
        sh_res  = d;
        sh_cf   = r_flags.cf;
        kk      = 5'd0;
        case (r_op)
            x86alu_pkg::OP_ADD, x86alu_pkg::OP_ADC: begin
                sum = {1'b0, d} + {1'b0, s} + {32'd0, cin};
                n_res = {32'd0, sum[31:0] & m};
                n_flags.cf = |((sum >> w) & 33'h1);
                n_flags.of = |(~(d ^ s) & (d ^ sum[31:0]) & msb);
            end
            x86alu_pkg::OP_SUB, x86alu_pkg::OP_SBB: begin
                sum = {1'b0, d} - {1'b0, s} - {32'd0, cin};
                n_res = {32'd0, sum[31:0] & m};
                n_flags.cf = sum[32];
                n_flags.of = |((d ^ s) & (d ^ sum[31:0]) & msb);
            end
            x86alu_pkg::OP_AND, x86alu_pkg::OP_OR, x86alu_pkg::OP_XOR: begin
                if (r_op == x86alu_pkg::OP_AND) begin
                    n_res = {32'd0, d & s};
                end else if (r_op == x86alu_pkg::OP_OR) begin
                    n_res = {32'd0, d | s};
                end else begin
                    n_res = {32'd0, d ^ s};
                end
                n_flags.cf = 1'b0;
                n_flags.of = 1'b0;
            end
            x86alu_pkg::OP_SHL, x86alu_pkg::OP_SAL: begin
                if (k != 32'd0) begin
                    if (k <= {26'd0, w}) begin
                        kk = 5'(k - 32'd1);
                        // last bit out is bit w-k of d
                        sh_cf  = |(((d << kk) & m) & msb);
                        sh_res = (k < {26'd0, w}) ? ((d << k[4:0]) & m) : 32'd0;
                    end else begin
                        sh_cf  = 1'b0;
                        sh_res = 32'd0;
                    end
                    n_flags.cf = sh_cf;
                    if (k == 32'd1) begin
                        n_flags.of = (|(sh_res & msb)) ^ sh_cf;
                    end
                end
                n_res = {32'd0, sh_res};
            end
            x86alu_pkg::OP_SHR: begin
                if (k != 32'd0) begin
                    if (k <= {26'd0, w}) begin
                        kk = 5'(k - 32'd1);
                        sh_cf  = d[kk];
                        sh_res = (k < {26'd0, w}) ? (d >> k[4:0]) : 32'd0;
                    end else begin
                        sh_cf  = 1'b0;
                        sh_res = 32'd0;
                    end
                    n_flags.cf = sh_cf;
                    if (k == 32'd1) begin
                        n_flags.of = |(d & msb);
                    end
                end
                n_res = {32'd0, sh_res};
            end
            x86alu_pkg::OP_SAR: begin
                if (k != 32'd0) begin
                    if (k >= {26'd0, w}) begin
                        sh_cf  = sxd[31];
                        sh_res = {32{sxd[31]}} & m;
                    end else begin
                        kk = 5'(k - 32'd1);
                        sh_cf  = sxd[kk];
                        sh_res = sar_v & m;
                    end
                    n_flags.cf = sh_cf;
                    if (k == 32'd1) begin
                        n_flags.of = 1'b0;
                    end
                end
                n_res = {32'd0, sh_res};
            end
            default: n_res = 64'd0;
        endcase
        par = ~^n_res[7:0];
        if (r_op <= x86alu_pkg::OP_SAR) begin
            n_flags.pf = par;
            n_flags.zf = ((n_res[31:0] & m) == 32'd0);
            n_flags.sf = |(n_res[31:0] & msb);
        end
    end

    // multiply: product registered, flags next cycle
    logic [31:0]        sxs;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic [63:0] psx;
    logic        mul_big;
    assign sxs   = x86alu_pkg::sx32(s, r_size);
    assign mul_a = (r_op == x86alu_pkg::OP_IMUL) ? $signed({sxd[31], sxd})
                                                 : $signed({1'b0, d});
    assign mul_b = (r_op == x86alu_pkg::OP_IMUL) ? $signed({sxs[31], sxs})
                                                 : $signed({1'b0, s});
    assign mul_p = mul_a * mul_b;

    always_comb begin
        case (r_size)
            x86alu_pkg::SZ_8:  psx = {{56{r_prod[7]}}, r_prod[7:0]};
            x86alu_pkg::SZ_16: psx = {{48{r_prod[15]}}, r_prod[15:0]};
            default:           psx = {{32{r_prod[31]}}, r_prod[31:0]};
        endcase
        if (r_op == x86alu_pkg::OP_IMUL) begin
            mul_big = (psx != r_prod);
        end else begin
            mul_big = ((r_prod >> w) != 64'd0);
        end
    end

    // divider step
    logic [32:0] trial;
    logic [32:0] rem_sh;
    assign rem_sh = {r_rem[31:0], r_quo[63]};
    assign trial  = rem_sh - {1'b0, r_dvs};

    logic [63:0] q_fix;
    logic [31:0] r_fix;
    assign q_fix = r_nq ? (64'd0 - r_quo) : r_quo;
    assign r_fix = r_nr ? (32'd0 - r_rem[31:0]) : r_rem[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (i_cmd.fast) begin
            r_flags <= n_flags;
        end else if (i_cmd.mul_fin) begin
            r_flags.cf <= mul_big;
            r_flags.of <= mul_big;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_req_type;
            r_src  <= i_src;
            r_dest <= i_dest;
            r_size <= i_size;
        end
        if (i_cmd.fast) begin
            r_res  <= n_res;
            r_derr <= is_div_op;
        end
        r_prod <= mul_p[63:0];
        if (i_cmd.mul_fin) begin
            r_res  <= r_prod;
            r_derr <= 1'b0;
        end
        if (i_cmd.div_init) begin
            r_quo <= signed_div ? (dvd_s[63] ? (64'd0 - dvd_s) : dvd_s) : dvd_u;
            r_dvs <= (signed_div && sdv[31]) ? (32'd0 - sdv) : sdv;
            r_rem <= 33'd0;
            r_cnt <= 7'd0;
            r_nq  <= signed_div && (dvd_s[63] ^ sdv[31]);
            r_nr  <= signed_div && dvd_s[63];
        end else if (i_cmd.div_step) begin
            if (!trial[32]) begin
                r_rem <= trial;
                r_quo <= {r_quo[62:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_quo <= {r_quo[62:0], 1'b0};
            end
            r_cnt <= r_cnt + 7'd1;
        end
        if (i_cmd.div_fin) begin
            r_derr <= 1'b0;
        end
    end

    // final quotient/remainder available after the last step writes r_quo/r_rem
    logic r_div_done;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_done <= 1'b0;
        end else if (i_cmd.load) begin
            r_div_done <= 1'b0;
        end else if (i_cmd.div_fin) begin
            r_div_done <= 1'b1;
        end
    end

    always_comb begin
        if (r_div_done) begin
            if ((r_op == x86alu_pkg::OP_DIV) || (r_op == x86alu_pkg::OP_IDIV)) begin
                o_result = {32'd0, q_fix[31:0] & m};
            end else begin
                o_result = {32'd0, r_fix & m};
            end
        end else begin
            o_result = r_res;
        end
    end

    assign o_flags = r_flags;
    assign o_derr  = r_derr;

endmodule

[src/x86_integer_alu_with_flags_top.sv]
// ----------------------------------------------------------------------------
// x86_integer_alu_with_flags_top
// x86 integer alu with kept cf/pf/zf/sf/of flags on stream ports
// ----------------------------------------------------------------------------
// sequence: the input beat is captured and decoded; add/logic/shift, unused codes
// and zero-divisor divides then give the result beat, mul/imul first register
// the product, div/idiv/mod/imod first run 64 steps of the shared restoring divider
// throughput: one beat in flight; the next input waits for the result handshake
// reset: synchronous active-low i_rst_n clears the flags and the sequencer
module x86_integer_alu_with_flags_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // req_type[4:0], src_operand[36:5], dest_operand[100:37], size_sel[102:101]
    input  logic [x86alu_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // result_value[63:0], carry_out[64], parity_out[65], zero_out[66],
    // negative_out[67], overflow_out[68], divide_error[69]
    output logic [x86alu_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    x86alu_pkg::t_cmd   w_cmd;
    x86alu_pkg::t_stat  w_stat;
    x86alu_pkg::t_flags w_flags;
    logic [63:0]        w_res;
    logic               w_derr;

    x86alu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    x86alu_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_req_type (s_axis_tdata[4:0]),
        .i_src      (s_axis_tdata[36:5]),
        .i_dest     (s_axis_tdata[100:37]),
        .i_size     (s_axis_tdata[102:101]),
        .o_result   (w_res),
        .o_flags    (w_flags),
        .o_derr     (w_derr)
    );

    assign m_axis_tdata = {2'b00, w_derr, w_flags.of, w_flags.sf, w_flags.zf,
                           w_flags.pf, w_flags.cf, w_res};

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input and output open together");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load, w_cmd.fast, w_cmd.mul_fin, w_cmd.div_init, w_cmd.div_step}))
        else $error("conflicting datapath commands");

endmodule
